[rtl/core/sqvs_pkg.sv]
// ----------------------------------------------------------------------------
// sqvs_pkg
// Types and constants shared by the sprite quad vertex setup block.
// ----------------------------------------------------------------------------
package sqvs_pkg;

  localparam int ATAN_ENTRIES = 20;

  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [31:0] CORDIC_K_Q30 = 32'sd652032875;
  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [21:0] VERT_MAX    = 22'sd2097151;
  localparam logic signed [21:0] VERT_MIN    = -22'sd2097152;

  // arctan(2^-i) in Q.16 radians, rounded to nearest
  localparam logic signed [19:0] ATAN_Q16 [ATAN_ENTRIES] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091,
    20'sd2047,  20'sd1024,  20'sd512,   20'sd256,  20'sd128,
    20'sd64,    20'sd32,    20'sd16,    20'sd8,    20'sd4,
    20'sd2,     20'sd1,     20'sd0,     20'sd0,    20'sd0
  };

  typedef struct packed {
    logic              zero;
    logic              neg;
    logic [23:0]       ox;
    logic [23:0]       oy;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [15:0]       depth;
  } side_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [19:0] z;
    side_t              side;
  } cdc_t;

endpackage

[rtl/core/sqvs_in_if.sv]
// ----------------------------------------------------------------------------
// sqvs_in_if
// Sprite input channel: valid/ready handshake with the sprite fields.
// ----------------------------------------------------------------------------
interface sqvs_in_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] pos_x;
  logic signed [19:0] pos_y;
  logic [11:0]        scale;
  logic signed [15:0] angle;
  logic [15:0]        depth;
  logic [11:0]        width;
  logic [11:0]        height;

  modport source (output valid, pos_x, pos_y, scale, angle, depth, width, height,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, scale, angle, depth, width, height,
                  output ready);
endinterface

[rtl/core/sqvs_out_if.sv]
// ----------------------------------------------------------------------------
// sqvs_out_if
// Vertex output channel: valid/ready handshake with one quad corner.
// ----------------------------------------------------------------------------
interface sqvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [21:0] vert_x;
  logic signed [21:0] vert_y;
  logic [15:0]        vert_z;
  logic               tex_u;
  logic               tex_v;
  logic [1:0]         corner;
  logic               last;

  modport source (output valid, vert_x, vert_y, vert_z, tex_u, tex_v, corner, last,
                  input ready);
  modport sink   (input valid, vert_x, vert_y, vert_z, tex_u, tex_v, corner, last,
                  output ready);
endinterface

[rtl/core/sqvs_cordic_cell.sv]
// ----------------------------------------------------------------------------
// sqvs_cordic_cell
// One rotation-mode CORDIC micro-rotation; passes the sprite data along.
// ----------------------------------------------------------------------------
module sqvs_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  sqvs_pkg::cdc_t in_data,
  output logic          out_valid,
  output sqvs_pkg::cdc_t out_data
);

  logic               valid_r;
  sqvs_pkg::cdc_t     data_r;
  sqvs_pkg::cdc_t     data_nxt;
  logic signed [31:0] x_in;
  logic signed [31:0] y_in;
  logic signed [19:0] z_in;
  logic signed [31:0] x_sh;
  logic signed [31:0] y_sh;

  assign x_in = in_data.x;
  assign y_in = in_data.y;
  assign z_in = in_data.z;
  assign x_sh = x_in >>> STEP;
  assign y_sh = y_in >>> STEP;

  always_comb begin
    data_nxt      = in_data;
    if (!z_in[19]) begin
      data_nxt.x = x_in - y_sh;
      data_nxt.y = y_in + x_sh;
      data_nxt.z = z_in - sqvs_pkg::ATAN_Q16[STEP];
    end else begin
      data_nxt.x = x_in + y_sh;
      data_nxt.y = y_in - x_sh;
      data_nxt.z = z_in + sqvs_pkg::ATAN_Q16[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[rtl/core/sqvs_corner_gen.sv]
// ----------------------------------------------------------------------------
// sqvs_corner_gen
// Rounds cos/sin, then expands one sprite into four rotated, saturated corners.
// ----------------------------------------------------------------------------
module sqvs_corner_gen (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tail_valid,
  input  sqvs_pkg::cdc_t   tail_data,
  output logic             take,
  sqvs_out_if.source       out_vert
);

  // sprite hold register
  logic               busy_r;
  logic [1:0]         k_r;
  logic signed [15:0] c_r;
  logic signed [15:0] s_r;
  logic [23:0]        ox_r;
  logic [23:0]        oy_r;
  logic signed [19:0] px_r;
  logic signed [19:0] py_r;
  logic [15:0]        dep_r;

  // product stage
  logic               a_valid_r;
  logic signed [40:0] a_xc_r, a_ys_r, a_xs_r, a_yc_r;
  logic signed [19:0] a_px_r, a_py_r;
  logic [15:0]        a_dep_r;
  logic [1:0]         a_k_r;

  // sum stage
  logic               b_valid_r;
  logic signed [41:0] b_rx_r, b_ry_r;
  logic signed [19:0] b_px_r, b_py_r;
  logic [15:0]        b_dep_r;
  logic [1:0]         b_k_r;

  // output register
  logic               o_valid_r;
  logic signed [21:0] o_vx_r, o_vy_r;
  logic [15:0]        o_dep_r;
  logic [1:0]         o_k_r;

  logic               post_adv;
  logic               emit;
  logic signed [31:0] tx;
  logic signed [31:0] ty;
  logic signed [32:0] xr;
  logic signed [32:0] yr;
  logic signed [16:0] xq;
  logic signed [16:0] yq;
  logic signed [15:0] c_nxt;
  logic signed [15:0] s_nxt;
  logic signed [24:0] oxe;
  logic signed [24:0] oye;
  logic signed [41:0] rnd;
  logic signed [24:0] vx_sum;
  logic signed [24:0] vy_sum;
  logic signed [21:0] vx_nxt;
  logic signed [21:0] vy_nxt;

  assign post_adv = !o_valid_r || out_vert.ready;
  assign emit     = busy_r && post_adv;
  assign take     = tail_valid && (!busy_r || (emit && (k_r == 2'd3)));

  function automatic logic signed [15:0] clamp_q14(input logic signed [16:0] v);
    if (v > 17'sd16384) begin
      return sqvs_pkg::ONE_Q14;
    end else if (v < -17'sd16384) begin
      return -sqvs_pkg::ONE_Q14;
    end else begin
      return v[15:0];
    end
  endfunction

  function automatic logic signed [21:0] sat22(input logic signed [24:0] v);
    if (v > 25'(sqvs_pkg::VERT_MAX)) begin
      return sqvs_pkg::VERT_MAX;
    end else if (v < 25'(sqvs_pkg::VERT_MIN)) begin
      return sqvs_pkg::VERT_MIN;
    end else begin
      return v[21:0];
    end
  endfunction

  assign tx = tail_data.x;
  assign ty = tail_data.y;
  assign xr = 33'(tx) + 33'sd32768;
  assign yr = 33'(ty) + 33'sd32768;
  assign xq = xr[32:16];
  assign yq = yr[32:16];

  always_comb begin
    if (tail_data.side.zero) begin
      c_nxt = sqvs_pkg::ONE_Q14;
      s_nxt = 16'sd0;
    end else if (tail_data.side.neg) begin
      c_nxt = -clamp_q14(xq);
      s_nxt = -clamp_q14(yq);
    end else begin
      c_nxt = clamp_q14(xq);
      s_nxt = clamp_q14(yq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 2'd0;
    end else if (take) begin
      busy_r <= 1'b1;
      k_r    <= 2'd0;
    end else if (emit) begin
      busy_r <= (k_r != 2'd3);
      k_r    <= k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      c_r   <= c_nxt;
      s_r   <= s_nxt;
      ox_r  <= tail_data.side.ox;
      oy_r  <= tail_data.side.oy;
      px_r  <= tail_data.side.pos_x;
      py_r  <= tail_data.side.pos_y;
      dep_r <= tail_data.side.depth;
    end
  end

  assign oxe = k_r[0] ? $signed({1'b0, ox_r}) : 25'sd0;
  assign oye = k_r[1] ? $signed({1'b0, oy_r}) : 25'sd0;

  assign rnd    = 42'sd131072;
  assign vx_sum = 25'(b_px_r) + 25'($signed(b_rx_r[41:18]));
  assign vy_sum = 25'(b_py_r) + 25'($signed(b_ry_r[41:18]));
  assign vx_nxt = sat22(vx_sum);
  assign vy_nxt = sat22(vy_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (post_adv) begin
      a_valid_r <= emit;
      b_valid_r <= a_valid_r;
      o_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (post_adv) begin
      a_xc_r  <= 41'(oxe) * 41'(c_r);
      a_ys_r  <= 41'(oye) * 41'(s_r);
      a_xs_r  <= 41'(oxe) * 41'(s_r);
      a_yc_r  <= 41'(oye) * 41'(c_r);
      a_px_r  <= px_r;
      a_py_r  <= py_r;
      a_dep_r <= dep_r;
      a_k_r   <= k_r;

      b_rx_r  <= 42'(a_xc_r) - 42'(a_ys_r) + rnd;
      b_ry_r  <= 42'(a_xs_r) + 42'(a_yc_r) + rnd;
      b_px_r  <= a_px_r;
      b_py_r  <= a_py_r;
      b_dep_r <= a_dep_r;
      b_k_r   <= a_k_r;

      o_vx_r  <= vx_nxt;
      o_vy_r  <= vy_nxt;
      o_dep_r <= b_dep_r;
      o_k_r   <= b_k_r;
    end
  end

  assign out_vert.valid  = o_valid_r;
  assign out_vert.vert_x = o_vx_r;
  assign out_vert.vert_y = o_vy_r;
  assign out_vert.vert_z = o_dep_r;
  assign out_vert.tex_u  = o_k_r[0];
  assign out_vert.tex_v  = o_k_r[1];
  assign out_vert.corner = o_k_r;
  assign out_vert.last   = (o_k_r == 2'd3);

endmodule

[rtl/core/sprite_quad_vertex_setup_top.sv]
// Order: prep register, CORDIC cells, corner expander hold, product, sum and
// output registers. The corner expander puts one corner a cycle on the output
// channel unless out_vert.ready stalls it; the cell chain holds the next
// sprites meanwhile. Reset (rst_n low, synchronous) clears all valid bits.
// ----------------------------------------------------------------------------
// sprite_quad_vertex_setup_top
// Rotated sprite quad expansion: prep stage, CORDIC cell chain, corner output.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_setup_top #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  sqvs_in_if.sink    in_sprite,
  sqvs_out_if.source out_vert
);

  logic               chain_adv;
  logic               take;
  logic               valid_c [CORDIC_STEPS+1];
  sqvs_pkg::cdc_t     data_c  [CORDIC_STEPS+1];
  logic               prep_valid_r;
  sqvs_pkg::cdc_t     prep_r;
  sqvs_pkg::cdc_t     prep_nxt;
  logic signed [19:0] z8;

  assign chain_adv       = !valid_c[CORDIC_STEPS] || take;
  assign in_sprite.ready = chain_adv;

  assign z8 = {in_sprite.angle[15], in_sprite.angle, 3'b000};

  always_comb begin
    prep_nxt            = '0;
    prep_nxt.x          = sqvs_pkg::CORDIC_K_Q30;
    prep_nxt.y          = 32'sd0;
    prep_nxt.side.zero  = (in_sprite.angle == 16'sd0);
    prep_nxt.side.ox    = 24'(in_sprite.width) * 24'(in_sprite.scale);
    prep_nxt.side.oy    = 24'(in_sprite.height) * 24'(in_sprite.scale);
    prep_nxt.side.pos_x = in_sprite.pos_x;
    prep_nxt.side.pos_y = in_sprite.pos_y;
    prep_nxt.side.depth = in_sprite.depth;
    if (z8 > sqvs_pkg::HALF_PI_Q16) begin
      prep_nxt.z        = z8 - sqvs_pkg::PI_Q16;
      prep_nxt.side.neg = 1'b1;
    end else if (z8 < -sqvs_pkg::HALF_PI_Q16) begin
      prep_nxt.z        = z8 + sqvs_pkg::PI_Q16;
      prep_nxt.side.neg = 1'b1;
    end else begin
      prep_nxt.z        = z8;
      prep_nxt.side.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (chain_adv) begin
      prep_valid_r <= in_sprite.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_adv) begin
      prep_r <= prep_nxt;
    end
  end

  assign valid_c[0] = prep_valid_r;
  assign data_c[0]  = prep_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    sqvs_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (chain_adv),
      .in_valid  (valid_c[i]),
      .in_data   (data_c[i]),
      .out_valid (valid_c[i+1]),
      .out_data  (data_c[i+1])
    );
  end

  sqvs_corner_gen u_corner (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail_valid (valid_c[CORDIC_STEPS]),
    .tail_data  (data_c[CORDIC_STEPS]),
    .take       (take),
    .out_vert   (out_vert)
  );

endmodule

[rtl/core/sqvs_checker.sv]
// ----------------------------------------------------------------------------
// sqvs_checker
// Port-level checks on the vertex output channel, bound to the top level.
// ----------------------------------------------------------------------------
module sqvs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [21:0] out_vert_x,
  input logic [1:0]         out_corner,
  input logic               out_last,
  input logic               out_tex_u,
  input logic               out_tex_v
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vert_x) && $stable(out_corner))
    else $error("output changed during a stalled transfer");

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_corner == 2'd3)))
    else $error("last flag does not match the fourth corner");

  a_tex_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tex_u == out_corner[0]) && (out_tex_v == out_corner[1]))
    else $error("texture coordinates do not match corner bits");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sprite_quad_vertex_setup_top sqvs_checker u_sqvs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_vert.valid),
  .out_ready  (out_vert.ready),
  .out_vert_x (out_vert.vert_x),
  .out_corner (out_vert.corner),
  .out_last   (out_vert.last),
  .out_tex_u  (out_vert.tex_u),
  .out_tex_v  (out_vert.tex_v)
);
